// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked assertion, muted while reset is active
`define ASSERT_CLK_RST(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);
// shorthand for the block clock and reset
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_CLK_RST(lbl, clk, arst_n, prop, msg)
`else
`define ASSERT_CLK_RST(lbl, clk_i, rstn_i, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif

`endif

// ===== sv/scd_pkg.sv =====
// ---------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the SCAN disk scheduler.
// ---------------------------------------------------------------------------
package scd_pkg;

	localparam int CYL_W       = 16;
	localparam int SEEK_W      = 22;
	localparam int MAX_REQ_DEF = 63;

	localparam logic [CYL_W-1:0] TOP_RESET = 16'd199;

	// one input item
	typedef struct packed {
		logic [CYL_W-1:0] start_head;
		logic [CYL_W-1:0] request_cylinder;
		logic             last_request;
	} scd_in_t;

	// one result item
	typedef struct packed {
		logic [CYL_W-1:0]  move_from;
		logic [CYL_W-1:0]  move_to;
		logic [SEEK_W-1:0] total_seek;
		logic              last_move;
	} scd_out_t;

	// schedule launch from the loader to the sequencer
	typedef struct packed {
		logic             go;
		logic [CYL_W-1:0] head;
		logic [CYL_W-1:0] top;
	} scd_cmd_t;

endpackage

// ===== sv/scd_req_mem.sv =====
// ---------------------------------------------------------------------------
// scd_req_mem
// Request store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module scd_req_mem
	import scd_pkg::*;
#(
	parameter int DEPTH = MAX_REQ_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [CYL_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [CYL_W-1:0] rd_data
);

	logic [CYL_W-1:0] mem_q [DEPTH];
	logic [CYL_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/scd_sched.sv =====
// ---------------------------------------------------------------------------
// scd_sched
// Schedule sequencer: one memory scan per move picks the next cylinder in
// SCAN order, then emits the move with its running seek total.
// ---------------------------------------------------------------------------
module scd_sched
	import scd_pkg::*;
#(
	parameter int MAX_REQUESTS = MAX_REQ_DEF,
	parameter int CW = $clog2(MAX_REQUESTS + 1),
	parameter int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scd_cmd_t         cmd,
	input  logic [CW-1:0]    cnt,
	output logic             rd_en,
	output logic [IW-1:0]    rd_addr,
	input  logic [CYL_W-1:0] rd_data,
	output logic             busy,
	output logic             res_valid,
	output scd_out_t         res
);

	localparam int KW = CYL_W + CW;
	// index above every stored entry; key {head, SENT} splits above/at-or-below
	localparam logic [CW-1:0] SENT = CW'(MAX_REQUESTS);

	typedef enum logic {S_IDLE, S_SCAN} state_t;
	typedef enum logic {PH_UP, PH_DOWN} phase_t;

	state_t           state_q;
	phase_t           phase_q;
	logic [CW-1:0]    cnt_q;
	logic [CYL_W-1:0] head_q;
	logic [CYL_W-1:0] top_q;
	logic [CW-1:0]    ptr_q;
	logic             vld_s1;
	logic [CW-1:0]    idx_s1;
	logic [KW-1:0]    cur_q;
	logic [KW-1:0]    best_q;
	logic             found_q;
	logic [CW-1:0]    emitted_q;
	logic [CYL_W-1:0] pos_q;
	logic [SEEK_W-1:0] total_q;
	logic             res_valid_q;
	scd_out_t         res_q;

	logic              issue;
	logic              scan_done;
	logic [KW-1:0]     key_s1;
	logic              hit;
	logic [CYL_W-1:0]  target;
	logic [CYL_W-1:0]  move_dist;
	logic [SEEK_W-1:0] total_nxt;
	logic              final_mv;

	// read issue over the loaded entries
	assign issue     = (state_q == S_SCAN) && (ptr_q != cnt_q);
	assign rd_en     = issue;
	assign rd_addr   = ptr_q[IW-1:0];
	assign scan_done = (state_q == S_SCAN) && (ptr_q == cnt_q) && !vld_s1;

	// key = {cylinder, index}: ties between equal cylinders break by index
	assign key_s1 = {rd_data, idx_s1};

	always_comb begin
		hit = 1'b0;
		if (vld_s1) begin
			case (phase_q)
				PH_UP:   hit = (key_s1 > cur_q) && (!found_q || (key_s1 < best_q));
				PH_DOWN: hit = (key_s1 < cur_q) && (!found_q || (key_s1 > best_q));
				default: hit = 1'b0;
			endcase
		end
	end

	// move target: next pick, or the top cylinder at the turn
	assign target    = found_q ? best_q[KW-1 -: CYL_W] : top_q;
	assign move_dist = (target >= pos_q) ? (target - pos_q) : (pos_q - target);
	assign total_nxt = total_q + SEEK_W'(move_dist);
	assign final_mv  = (emitted_q == cnt_q);

	// sequencer state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_UP;
			cnt_q       <= '0;
			head_q      <= '0;
			top_q       <= '0;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			cur_q       <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			emitted_q   <= '0;
			pos_q       <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			vld_s1      <= issue;
			idx_s1      <= ptr_q;
			case (state_q)
				S_IDLE: begin
					if (cmd.go) begin
						state_q   <= S_SCAN;
						phase_q   <= PH_UP;
						cnt_q     <= cnt;
						head_q    <= cmd.head;
						top_q     <= cmd.top;
						cur_q     <= {cmd.head, SENT};
						ptr_q     <= '0;
						found_q   <= 1'b0;
						emitted_q <= '0;
						pos_q     <= cmd.head;
						total_q   <= '0;
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit) begin
						best_q  <= key_s1;
						found_q <= 1'b1;
					end
					if (scan_done) begin
						res_valid_q         <= 1'b1;
						res_q.move_from     <= pos_q;
						res_q.move_to       <= target;
						res_q.total_seek    <= total_nxt;
						res_q.last_move     <= final_mv;
						pos_q               <= target;
						total_q             <= total_nxt;
						emitted_q           <= emitted_q + 1'b1;
						ptr_q               <= '0;
						found_q             <= 1'b0;
						if (found_q) begin
							cur_q <= best_q;
						end else begin
							// turn at the top, then sweep down
							phase_q <= PH_DOWN;
							cur_q   <= {head_q, SENT};
						end
						if (final_mv) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/scan_disk_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// scan_disk_scheduler_unit
// SCAN (elevator) disk scheduler: loads a batch of requests, then emits the
// head moves in SCAN order with the running seek total.
// ---------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  request   | start & !busy        | scd_in_t (head, cylinder, last)
//  result    | result_valid strobe  | scd_out_t (from, to, total, last)
//  config    | cfg_we               | cfg_data -> top_cylinder
//
// A request item is taken when start is high and busy is low. After the last
// item of a batch of N requests the block emits N+1 moves, each after one
// full scan of the request memory through its single read port, with busy
// high throughout. Reset clears counts and the sequencer; the request memory
// needs no clearing. Results are one-cycle strobes and cannot be held off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scan_disk_scheduler_unit
	import scd_pkg::*;
#(
	parameter int MAX_REQUESTS = MAX_REQ_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  scd_in_t          request,
	output logic             result_valid,
	output scd_out_t         result,
	input  logic             cfg_we,
	input  logic [CYL_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	logic [CYL_W-1:0] top_q;
	logic [CW-1:0]    count_q;
	logic [CYL_W-1:0] head_q;

	logic             accept;
	logic             full;
	logic [CYL_W-1:0] req_clamped;
	logic [CW-1:0]    cnt_next;
	scd_cmd_t         cmd;
	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic [CYL_W-1:0] rd_data;
	logic             sched_busy;

	// item intake
	assign accept      = start && !busy;
	assign full        = (count_q == CW'(MAX_REQUESTS));
	assign req_clamped = (request.request_cylinder > top_q) ? top_q : request.request_cylinder;
	assign cnt_next    = full ? count_q : (count_q + 1'b1);

	assign cmd.go   = accept && request.last_request;
	assign cmd.head = (count_q == '0) ? request.start_head : head_q;
	assign cmd.top  = top_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= TOP_RESET;
		end else if (cfg_we) begin
			top_q <= cfg_data;
		end
	end

	// batch fill count and start head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (accept) begin
			if (count_q == '0) begin
				head_q <= request.start_head;
			end
			count_q <= request.last_request ? '0 : cnt_next;
		end
	end

	scd_req_mem #(
		.DEPTH (MAX_REQUESTS),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (accept && !full),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (req_clamped),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	scd_sched #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.CW           (CW),
		.IW           (IW)
	) u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cnt       (cnt_next),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.busy      (sched_busy),
		.res_valid (result_valid),
		.res       (result)
	);

	assign busy = sched_busy;

	// checks
	`ASSERT_STD(a_go_busy, cmd.go |=> busy, "schedule did not start after last item")
	`ASSERT_STD(a_last_idle, result_valid && result.last_move |-> !busy, "busy after final move")
	`ASSERT_STD(a_mid_busy, result_valid && !result.last_move |-> busy, "idle before final move")
	`ASSERT_STD(a_cnt_clr, busy |-> (count_q == '0), "batch count not cleared during schedule")

endmodule

// ===== sim/scan_disk_scheduler_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scan_disk_scheduler_unit_test
// Self-checking bench for the SCAN disk scheduler. A short list of directed
// batches (extreme cylinders, clamping, head above top, equal and duplicate
// requests, top register extremes) is followed by random batches of random
// size, some of them past the store limit. Every accepted request goes into
// a local SCAN planner. Its predicted head moves, or typed ones for single
// directed requests, are compared field by field with each result strobe.
// ---------------------------------------------------------------------------
module scan_disk_scheduler_unit_test;
	import scd_pkg::*;

	localparam int NO_WRITE   = -1;
	localparam int BATCH_ITEMS = 360;
	localparam int SETTLE_CYC = 8;
	localparam int MAX_SHOWN  = 40;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	scd_in_t          request;
	logic             result_valid;
	scd_out_t         result;
	logic             cfg_we;
	logic [CYL_W-1:0] cfg_data;

	scan_disk_scheduler_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	// one directed row: optional top write before it, the item, typed moves
	typedef struct {
		int       top_write;
		scd_in_t  item;
		int       n_typed;
		scd_out_t typed0;
		scd_out_t typed1;
	} dir_row_t;

	dir_row_t dir_rows[$];

	// planner state
	logic [CYL_W-1:0] sched_top;
	logic [CYL_W-1:0] sched_store[MAX_REQ_DEF];
	int               sched_count;
	logic [CYL_W-1:0] sched_head;

	scd_out_t scan_moves[$];  // moves planned for the latest item
	scd_out_t due_moves[$];   // moves still awaited from the block
	int       errors;
	int       issued;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(string what);
		if (errors < MAX_SHOWN)
			$display("mismatch at %0t ns: %s", $time, what);
		errors++;
	endtask

	function automatic scd_out_t mv(int from_c, int to_c, int tot, bit lm);
		scd_out_t m;
		m.move_from  = from_c[CYL_W-1:0];
		m.move_to    = to_c[CYL_W-1:0];
		m.total_seek = tot[SEEK_W-1:0];
		m.last_move  = lm;
		return m;
	endfunction

	// SCAN planner: store the request, emit the move list on the last one
	function automatic void plan_scan(scd_in_t it);
		logic [CYL_W-1:0]  req;
		logic [CYL_W-1:0]  c;
		logic [CYL_W-1:0]  d;
		logic [CYL_W-1:0]  up[MAX_REQ_DEF];
		logic [CYL_W-1:0]  dn[MAX_REQ_DEF];
		logic [CYL_W-1:0]  path[MAX_REQ_DEF+2];
		logic [SEEK_W-1:0] total;
		scd_out_t          m;
		int                nup, ndn, np, j;
		scan_moves.delete();
		if (sched_count == 0)
			sched_head = it.start_head;
		req = (it.request_cylinder > sched_top) ? sched_top : it.request_cylinder;
		// store full: the request is dropped
		if (sched_count < MAX_REQ_DEF) begin
			sched_store[sched_count] = req;
			sched_count++;
		end
		if (!it.last_request)
			return;
		// split around the head, ascending above, descending at or below
		nup = 0;
		ndn = 0;
		for (int i = 0; i < sched_count; i++) begin
			c = sched_store[i];
			if (c > sched_head) begin
				j = nup;
				while (j > 0 && up[j-1] > c) begin
					up[j] = up[j-1];
					j--;
				end
				up[j] = c;
				nup++;
			end else begin
				j = ndn;
				while (j > 0 && dn[j-1] < c) begin
					dn[j] = dn[j-1];
					j--;
				end
				dn[j] = c;
				ndn++;
			end
		end
		// head path: up list, top, down list
		path[0] = sched_head;
		np = 1;
		for (int i = 0; i < nup; i++) begin
			path[np] = up[i];
			np++;
		end
		path[np] = sched_top;
		np++;
		for (int i = 0; i < ndn; i++) begin
			path[np] = dn[i];
			np++;
		end
		total = '0;
		for (int i = 0; i < np - 1; i++) begin
			d = (path[i+1] >= path[i]) ? path[i+1] - path[i] : path[i] - path[i+1];
			total = total + {{(SEEK_W-CYL_W){1'b0}}, d};
			m.move_from  = path[i];
			m.move_to    = path[i+1];
			m.total_seek = total;
			m.last_move  = (i == np - 2);
			scan_moves.push_back(m);
		end
		sched_head  = path[np-1];
		sched_count = 0;
	endfunction

	// hand one item over; called and returns at a falling edge
	task automatic issue_request(scd_in_t item, int unsigned gap, int n_typed = 0,
		scd_out_t t0 = '0, scd_out_t t1 = '0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy);
		plan_scan(item);
		if (n_typed > 0) begin
			due_moves.push_back(t0);
			if (n_typed > 1)
				due_moves.push_back(t1);
		end else begin
			foreach (scan_moves[i])
				due_moves.push_back(scan_moves[i]);
		end
		issued++;
		@(negedge clk);
	endtask

	// drain all moves, then let the block finish its schedule
	task automatic settle_idle(int unsigned extra);
		start <= 1'b0;
		while (due_moves.size() != 0)
			@(posedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_top(logic [CYL_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sched_top  = v;
	endtask

	task automatic add_row(int top_w, int head, int req, bit last, int n_typed = 0,
		scd_out_t m0 = '0, scd_out_t m1 = '0);
		dir_row_t r;
		r.top_write                   = top_w;
		r.item.start_head             = head[CYL_W-1:0];
		r.item.request_cylinder       = req[CYL_W-1:0];
		r.item.last_request           = last;
		r.n_typed                     = n_typed;
		r.typed0                      = m0;
		r.typed1                      = m1;
		dir_rows.push_back(r);
	endtask

	// result checker
	always @(posedge clk) begin : check_moves
		scd_out_t want;
		if (arst_n && result_valid) begin
			if (due_moves.size() == 0) begin
				report_mismatch($sformatf("move %0d->%0d with nothing expected",
					result.move_from, result.move_to));
			end else begin
				want = due_moves.pop_front();
				if (result.move_from !== want.move_from)
					report_mismatch($sformatf("move_from %0d, want %0d",
						result.move_from, want.move_from));
				if (result.move_to !== want.move_to)
					report_mismatch($sformatf("move_to %0d, want %0d",
						result.move_to, want.move_to));
				if (result.total_seek !== want.total_seek)
					report_mismatch($sformatf("total_seek %0d, want %0d",
						result.total_seek, want.total_seek));
				if (result.last_move !== want.last_move)
					report_mismatch($sformatf("last_move %0b, want %0b",
						result.last_move, want.last_move));
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		scd_in_t          it;
		int               bsize;
		int               big_batches;
		int               pick;
		bit               quiet;
		logic [CYL_W-1:0] head;
		logic [CYL_W-1:0] prev_req;
		logic [CYL_W-1:0] v;

		start       = 1'b0;
		request     = '0;
		cfg_we      = 1'b0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		errors      = 0;
		issued      = 0;
		sched_top   = TOP_RESET;
		sched_count = 0;
		sched_head  = '0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed batches; single requests are typed in, the rest planned
		add_row(NO_WRITE, 50, 100, 1, 2, mv(50, 100, 50, 0), mv(100, 199, 149, 1));
		add_row(NO_WRITE, 0, 0, 1, 2, mv(0, 199, 199, 0), mv(199, 0, 398, 1));
		// head above top, request clamped to top
		add_row(NO_WRITE, 65535, 65535, 1, 2,
			mv(65535, 199, 65336, 0), mv(199, 199, 65336, 1));
		// request equal to head is served on the way down
		add_row(NO_WRITE, 120, 120, 1, 2, mv(120, 199, 79, 0), mv(199, 120, 158, 1));
		// classic batch with a duplicate and a clamped request
		add_row(NO_WRITE, 53, 98, 0);
		add_row(NO_WRITE, 65535, 183, 0);
		add_row(NO_WRITE, 0, 37, 0);
		add_row(NO_WRITE, 12, 122, 0);
		add_row(NO_WRITE, 999, 14, 0);
		add_row(NO_WRITE, 53, 124, 0);
		add_row(NO_WRITE, 7, 65, 0);
		add_row(NO_WRITE, 1, 67, 0);
		add_row(NO_WRITE, 2, 65, 0);
		add_row(NO_WRITE, 3, 500, 1);
		// top at maximum
		add_row(65535, 0, 65535, 1, 2, mv(0, 65535, 65535, 0), mv(65535, 65535, 65535, 1));
		add_row(NO_WRITE, 65535, 0, 1, 2, mv(65535, 65535, 0, 0), mv(65535, 0, 65535, 1));
		// top at zero: everything clamps to cylinder 0
		add_row(0, 0, 0, 1, 2, mv(0, 0, 0, 0), mv(0, 0, 0, 1));
		add_row(NO_WRITE, 40000, 12345, 1, 2, mv(40000, 0, 40000, 0), mv(0, 0, 40000, 1));
		add_row(NO_WRITE, 7, 9, 0);
		add_row(NO_WRITE, 100, 3, 0);
		add_row(NO_WRITE, 200, 0, 1);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].top_write != NO_WRITE) begin
				settle_idle(SETTLE_CYC);
				write_top(dir_rows[i].top_write[CYL_W-1:0]);
			end
			issue_request(dir_rows[i].item, $urandom_range(0, 10), dir_rows[i].n_typed,
				dir_rows[i].typed0, dir_rows[i].typed1);
		end

		// random batches
		big_batches = 0;
		issued      = 0;
		while (issued < BATCH_ITEMS) begin
			// new top between batches, always at the first one
			if (issued == 0 || $urandom_range(0, 5) == 0) begin
				settle_idle(SETTLE_CYC);
				case ($urandom_range(0, 5))
					0:       v = '0;
					1:       v = '1;
					2:       v = TOP_RESET;
					3:       v = CYL_W'($urandom_range(1, 400));
					default: v = CYL_W'($urandom);
				endcase
				write_top(v);
			end

			// mostly small batches, a few near or past the store limit
			pick = $urandom_range(0, 99);
			if (pick < 4 && big_batches < 3) begin
				bsize = $urandom_range(MAX_REQ_DEF - 1, MAX_REQ_DEF + 7);
				big_batches++;
			end else if (pick < 25) begin
				bsize = $urandom_range(9, 24);
			end else begin
				bsize = $urandom_range(1, 8);
			end

			case ($urandom_range(0, 9))
				0:       head = '0;
				1:       head = '1;
				2:       head = sched_top;
				3, 4:    head = (sched_top == '1) ? '1 :
					CYL_W'($urandom_range(sched_top + 1, 65535));
				5:       head = CYL_W'($urandom);
				default: head = CYL_W'($urandom_range(0, sched_top));
			endcase

			quiet    = ($urandom_range(0, 3) == 0);
			prev_req = head;
			for (int n = 0; n < bsize; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					it.request_cylinder = head;
				else if (pick < 20)
					it.request_cylinder = prev_req;
				else if (pick < 30 && sched_top != '1)
					it.request_cylinder = CYL_W'($urandom_range(sched_top + 1, 65535));
				else if (pick < 40)
					it.request_cylinder = CYL_W'($urandom);
				else if (pick < 45)
					it.request_cylinder = '0;
				else
					it.request_cylinder = CYL_W'($urandom_range(0, sched_top));
				// start head only counts on the first item of a batch
				it.start_head   = (n == 0) ? head : CYL_W'($urandom);
				it.last_request = (n == bsize - 1);
				prev_req        = it.request_cylinder;
				issue_request(it, quiet ? 0 : $urandom_range(0, 10));
			end
		end

		settle_idle(20);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/scd_pkg.sv
sv/scd_req_mem.sv
sv/scd_sched.sv
sv/scan_disk_scheduler_unit.sv
sim/scan_disk_scheduler_unit_test.sv
